/* sv/lfu_pkg.sv */
package lfu_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int CAP_BITS    = 5;
  localparam int COUNT_BITS  = 32;
  localparam int STAMP_BITS  = 64;

  localparam logic [CAP_BITS-1:0]   CAP_RESET = CAP_BITS'(16);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_NEW = COUNT_BITS'(1);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_HOLD
  } lfu_state_t;

endpackage

/* sv/lfu_if.sv */
interface lfu_req_if
  import lfu_pkg::*;
#(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic        [KEY_BITS-1:0]   lookup_key;
  logic signed [VALUE_BITS-1:0] write_value;

  modport source (output valid, command, lookup_key, write_value, input ready);
  modport sink   (input valid, command, lookup_key, write_value, output ready);
endinterface

interface lfu_rsp_if
  import lfu_pkg::*;
#(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [VALUE_BITS-1:0] read_value;
  logic                         evicted;
  logic        [KEY_BITS-1:0]   evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lfu_cfg_if
  import lfu_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CAP_BITS-1:0] cache_capacity;

  modport source (output valid, cache_capacity, input ready);
  modport sink   (input valid, cache_capacity, output ready);
endinterface

/* sv/lfu_ram.sv */
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/lfu_cache_engine.sv */
// channel  dir  payload                                         beat when
// req      in   command, lookup_key, write_value                valid & ready
// rsp      out  hit, read_value, evicted, evicted_key           valid & ready
// cfg      in   cache_capacity                                  valid & ready
//
// one item takes one pass over the entry ram (one read per cycle, registered
// ram output), then the write-back state.
// a put at capacity zero skips the pass and goes straight to write-back.
// reset (rst, synchronous) clears the valid bits, fill count and stamp counter.
// a result waits in the rsp register; the next request is taken meanwhile, and
// its result holds in the engine until the rsp register frees.
module lfu_cache_engine
  import lfu_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  lfu_req_if.sink  req,
  lfu_rsp_if.source rsp,
  lfu_cfg_if.sink  cfg
);

  localparam int IDX_W  = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam int WORD_W = KEY_BITS + VALUE_BITS + COUNT_BITS + STAMP_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  lfu_state_t state, state_next;

  logic [CAP_BITS-1:0]   cap;
  logic [FILL_W-1:0]     fill;
  logic [FILL_W-1:0]     cap_eff;
  logic [STAMP_BITS-1:0] stamp;
  logic                  entry_valid [ENTRIES];

  // latched request
  logic                  req_put;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_val;
  logic                  skip;

  // scan
  logic [IDX_W-1:0]      scan_addr;
  logic                  issue_done;
  logic                  rd_pend;
  logic [IDX_W-1:0]      rd_idx;
  logic [WORD_W-1:0]     rdata;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] rd_count;
  logic [STAMP_BITS-1:0] rd_stamp;
  logic                  rd_live;

  logic                  found;
  logic [IDX_W-1:0]      found_idx;
  logic [VALUE_BITS-1:0] found_data;
  logic [COUNT_BITS-1:0] found_count;
  logic                  victim_any;
  logic [IDX_W-1:0]      victim_idx;
  logic [KEY_BITS-1:0]   victim_key;
  logic [COUNT_BITS-1:0] victim_count;
  logic [STAMP_BITS-1:0] victim_stamp;
  logic                  free_any;
  logic [IDX_W-1:0]      free_idx;

  // held result
  logic                  res_hit;
  logic [VALUE_BITS-1:0] res_value;
  logic                  res_evicted;
  logic [KEY_BITS-1:0]   res_key;

  // control
  logic                  req_take;
  logic                  rsp_free;
  logic                  rsp_load;
  logic                  do_hit;
  logic                  do_evict;
  logic                  do_free;
  logic                  do_insert;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [WORD_W-1:0]     wdata;
  logic [IDX_W-1:0]      ins_idx;
  logic [COUNT_BITS-1:0] count_inc;
  logic [VALUE_BITS-1:0] new_data;
  logic                  out_hit;
  logic [VALUE_BITS-1:0] out_value;
  logic                  out_evicted;
  logic [KEY_BITS-1:0]   out_key;

  lfu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (scan_addr),
    .rdata (rdata)
  );

  assign rd_key   = rdata[WORD_W-1 -: KEY_BITS];
  assign rd_data  = rdata[COUNT_BITS+STAMP_BITS +: VALUE_BITS];
  assign rd_count = rdata[STAMP_BITS +: COUNT_BITS];
  assign rd_stamp = rdata[STAMP_BITS-1:0];
  assign rd_live  = rd_pend && entry_valid[rd_idx];

  assign cap_eff = (32'(cap) >= 32'(ENTRIES)) ? FILL_W'(ENTRIES) : FILL_W'(cap);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg.valid) begin
      cap <= cfg.cache_capacity;
    end
  end

  // write-back decision, used in the write state
  always_comb begin
    do_hit    = !skip && found;
    do_evict  = !skip && !found && req_put && (fill >= cap_eff) && victim_any;
    do_free   = !skip && !found && req_put && !do_evict && free_any;
    do_insert = do_evict || do_free;
    ins_idx   = do_evict ? victim_idx : free_idx;
    count_inc = (found_count == COUNT_MAX) ? found_count : found_count + COUNT_BITS'(1);
    new_data  = (do_hit && !req_put) ? found_data : req_val;
    waddr     = do_hit ? found_idx : ins_idx;
    wdata     = {req_key, new_data, do_hit ? count_inc : COUNT_NEW, stamp};
    out_hit     = do_hit;
    out_value   = do_hit ? found_data : '0;
    out_evicted = do_evict;
    out_key     = do_evict ? victim_key : '0;
  end

  always_comb begin
    state_next = state;
    req_take   = 1'b0;
    rsp_load   = 1'b0;
    we         = 1'b0;
    rsp_free   = !rsp.valid || rsp.ready;
    case (state)
      ST_IDLE: begin
        req_take = req.valid;
        if (req.valid) begin
          if (req.command == CMD_PUT && cap_eff == '0) begin
            state_next = ST_WRITE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_pend && rd_idx == LAST_IDX) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        we       = do_hit || do_insert;
        rsp_load = rsp_free;
        state_next = rsp_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        rsp_load = rsp_free;
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request latch and scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend    <= 1'b0;
      issue_done <= 1'b0;
      scan_addr  <= '0;
      found      <= 1'b0;
      victim_any <= 1'b0;
      free_any   <= 1'b0;
      skip       <= 1'b0;
    end else if (req_take) begin
      req_put    <= req.command;
      req_key    <= req.lookup_key;
      req_val    <= req.write_value;
      skip       <= (req.command == CMD_PUT) && (cap_eff == '0);
      scan_addr  <= '0;
      issue_done <= 1'b0;
      rd_pend    <= 1'b0;
      found      <= 1'b0;
      victim_any <= 1'b0;
      free_any   <= 1'b0;
    end else if (state == ST_SCAN) begin
      rd_pend <= !issue_done;
      rd_idx  <= scan_addr;
      if (!issue_done) begin
        if (scan_addr == LAST_IDX) begin
          issue_done <= 1'b1;
        end else begin
          scan_addr <= scan_addr + IDX_W'(1);
        end
      end
      if (rd_live && !found && rd_key == req_key) begin
        found       <= 1'b1;
        found_idx   <= rd_idx;
        found_data  <= rd_data;
        found_count <= rd_count;
      end
      // lowest count wins, then oldest stamp; strict compare keeps the lowest slot
      if (rd_live && (!victim_any || rd_count < victim_count ||
                      (rd_count == victim_count && rd_stamp < victim_stamp))) begin
        victim_any   <= 1'b1;
        victim_idx   <= rd_idx;
        victim_key   <= rd_key;
        victim_count <= rd_count;
        victim_stamp <= rd_stamp;
      end
      if (rd_pend && !entry_valid[rd_idx] && !free_any) begin
        free_any <= 1'b1;
        free_idx <= rd_idx;
      end
    end else begin
      rd_pend <= 1'b0;
    end
  end

  // valid bits, fill count and stamp counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        entry_valid[i] <= 1'b0;
      end
      fill  <= '0;
      stamp <= '0;
    end else if (state == ST_WRITE) begin
      if (do_insert) begin
        entry_valid[ins_idx] <= 1'b1;
      end
      if (do_free) begin
        fill <= fill + FILL_W'(1);
      end
      if (do_hit || do_insert) begin
        stamp <= stamp + STAMP_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      res_hit     <= out_hit;
      res_value   <= out_value;
      res_evicted <= out_evicted;
      res_key     <= out_key;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      if (state == ST_WRITE) begin
        rsp.hit         <= out_hit;
        rsp.read_value  <= out_value;
        rsp.evicted     <= out_evicted;
        rsp.evicted_key <= out_key;
      end else begin
        rsp.hit         <= res_hit;
        rsp.read_value  <= res_value;
        rsp.evicted     <= res_evicted;
        rsp.evicted_key <= res_key;
      end
    end
  end

endmodule
